>>> design/chsa_pkg.sv
`timescale 1ns / 1ps
package chsa_pkg;

  localparam int ADDR_W      = 32;
  localparam int SIZE_W      = 24;
  localparam int ALIGN_W     = 4;
  localparam int ACTION_W    = 2;
  localparam int LOG2_W      = 5;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // heaps that have a base register
  localparam int BASE_REGS          = 4;
  localparam int HEAP_COUNT_DEFAULT = 4;

  localparam logic [LOG2_W-1:0] BASE_LOG2_MIN   = 5'd4;
  localparam logic [LOG2_W-1:0] BASE_LOG2_MAX   = 5'd24;
  localparam logic [LOG2_W-1:0] BASE_LOG2_RESET = 5'd12;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_SIZE_LOG2 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEAP0_BASE     = 3'd1;

  // actions
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POP   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESET = 2'd2;

  typedef struct packed {
    logic load_pos;
    logic load_fit;
  } try_ctrl_t;

  typedef struct packed {
    logic              fit;
    logic [ADDR_W-1:0] aligned;
    logic [ADDR_W-1:0] end_pos;
  } try_stat_t;

endpackage

>>> design/chsa_try_unit.sv
`timescale 1ns / 1ps
module chsa_try_unit (
  input  logic                                 clk,
  input  chsa_pkg::try_ctrl_t                  ctrl,
  input  logic [chsa_pkg::ADDR_W-1:0]          base,
  input  logic [chsa_pkg::ADDR_W-1:0]          off,
  input  logic [chsa_pkg::LOG2_W-1:0]          size_log2,
  input  logic [chsa_pkg::ALIGN_W-1:0]         align_log2,
  input  logic [chsa_pkg::SIZE_W-1:0]          alloc_size,
  output chsa_pkg::try_stat_t                  stat
);
  import chsa_pkg::*;

  localparam logic [ADDR_W:0] ADDR_LIMIT = {1'b1, {ADDR_W{1'b0}}};

  logic [ADDR_W+1:0] mask;
  logic [ADDR_W+1:0] pos_sum;
  logic [ADDR_W:0]   hsize;
  logic [ADDR_W:0]   end_raw;
  logic [ADDR_W:0]   end_lim;
  logic [ADDR_W+1:0] end_sum;

  logic [ADDR_W+1:0] aligned;
  logic [ADDR_W:0]   heap_end;
  logic [ADDR_W-1:0] end_pos;
  logic              fit;

  // first step: align base + offset up, heap end clipped to the address space; second step: allocation end
  always_comb begin
    mask    = ~({(ADDR_W+2){1'b1}} << align_log2);
    pos_sum = {2'b00, base} + {2'b00, off} + mask;
    hsize   = (ADDR_W+1)'(1) << size_log2;
    end_raw = {1'b0, base} + hsize;
    end_lim = (end_raw > ADDR_LIMIT) ? ADDR_LIMIT : end_raw;
    end_sum = aligned + (ADDR_W+2)'(alloc_size);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_pos) begin
      aligned  <= pos_sum & ~mask;
      heap_end <= end_lim;
    end
    if (ctrl.load_fit) begin
      end_pos <= end_sum[ADDR_W-1:0];
      fit     <= (aligned[ADDR_W+1:ADDR_W] == 2'b00) && (end_sum <= {1'b0, heap_end});
    end
  end

  assign stat.fit     = fit;
  assign stat.aligned = aligned[ADDR_W-1:0];
  assign stat.end_pos = end_pos;

endmodule

>>> design/chained_heap_stack_allocator_unit.sv
// pop, reset and unused actions go from accept straight to the result write
// allocate: search for the heap of the top one heap per step, then position, fit and commit
//   steps for each heap tried; a top past the last heap fails once every heap is searched
// throughput: one item at a time, the next is accepted the cycle after the result is loaded
// reset (rst, synchronous): top index 0, base size log2 12, all heap bases 0,
// no result pending
`timescale 1ns / 1ps
module chained_heap_stack_allocator_unit #(
  parameter int HEAP_COUNT = chsa_pkg::HEAP_COUNT_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [chsa_pkg::ACTION_W-1:0]       action,
  input  logic [chsa_pkg::SIZE_W-1:0]         alloc_size,
  input  logic [chsa_pkg::ALIGN_W-1:0]        align_log2,
  input  logic [chsa_pkg::ADDR_W-1:0]         pop_index,
  // result items
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [chsa_pkg::ADDR_W-1:0]         address,
  output logic                                granted,
  output logic [chsa_pkg::ADDR_W-1:0]         stack_top,
  // configuration writes
  input  logic                                cfg_write,
  input  logic [chsa_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [chsa_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import chsa_pkg::*;

  // heaps past the last base register are never used
  localparam int USED_HEAPS = (HEAP_COUNT < BASE_REGS) ? HEAP_COUNT : BASE_REGS;
  localparam int HW         = (USED_HEAPS > 1) ? $clog2(USED_HEAPS) : 1;
  localparam logic [HW-1:0] LAST_HEAP = HW'(USED_HEAPS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_POS,
    S_FIT,
    S_COMMIT,
    S_WRITE
  } state_t;

  state_t state;

  // configuration registers
  logic [LOG2_W-1:0] base_size_log2;
  logic [ADDR_W-1:0] heap_base [USED_HEAPS];

  // allocator state and the latched item
  logic [ADDR_W-1:0]  top_index;
  logic [SIZE_W-1:0]  req_size;
  logic [ALIGN_W-1:0] req_align;
  logic [HW-1:0]      heap;
  logic [ADDR_W-1:0]  off;
  logic [ADDR_W-1:0]  res_addr;
  logic               res_granted;

  logic [LOG2_W-1:0] eff_log2;
  logic [LOG2_W-1:0] heap_log2;
  logic [ADDR_W-1:0] heap_start;
  logic [ADDR_W-1:0] heap_size;
  logic [ADDR_W-1:0] base_sel;
  logic              in_heap;
  logic              out_free;

  try_ctrl_t try_ctrl;
  try_stat_t try_stat;

  // base size saturates to its legal range
  always_comb begin
    if (base_size_log2 < BASE_LOG2_MIN) begin
      eff_log2 = BASE_LOG2_MIN;
    end else if (base_size_log2 > BASE_LOG2_MAX) begin
      eff_log2 = BASE_LOG2_MAX;
    end else begin
      eff_log2 = base_size_log2;
    end
  end

  // heap h: indices start at B*(2^h - 1), size is B << h
  always_comb begin
    heap_log2  = eff_log2 + LOG2_W'(heap);
    heap_start = ((ADDR_W'(1) << heap) - ADDR_W'(1)) << eff_log2;
    heap_size  = ADDR_W'(1) << heap_log2;
    base_sel   = heap_base[heap];
    in_heap    = top_index < (heap_start + heap_size);
    out_free   = !out_valid || out_ready;
  end

  assign in_ready          = (state == S_IDLE);
  assign try_ctrl.load_pos = (state == S_POS);
  assign try_ctrl.load_fit = (state == S_FIT);

  chsa_try_unit u_try (
    .clk        (clk),
    .ctrl       (try_ctrl),
    .base       (base_sel),
    .off        (off),
    .size_log2  (heap_log2),
    .align_log2 (req_align),
    .alloc_size (req_size),
    .stat       (try_stat)
  );

  // configuration port, writes to heaps that do not exist are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      base_size_log2 <= BASE_LOG2_RESET;
      for (int i = 0; i < USED_HEAPS; i++) begin
        heap_base[i] <= '0;
      end
    end else if (cfg_write) begin
      if (cfg_index == REG_BASE_SIZE_LOG2) begin
        base_size_log2 <= cfg_data[LOG2_W-1:0];
      end
      for (int i = 0; i < USED_HEAPS; i++) begin
        if (cfg_index == REG_HEAP0_BASE + CFG_INDEX_W'(i)) begin
          heap_base[i] <= cfg_data;
        end
      end
    end
  end

  // sequencer: pop and reset set the top; allocate finds the heap of the top, then tries it and each following heap
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      top_index <= '0;
      out_valid <= 1'b0;
    end else begin
      // a result loaded in this cycle keeps out_valid high instead
      if (out_valid && out_ready && state != S_WRITE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_size    <= alloc_size;
            req_align   <= align_log2;
            heap        <= '0;
            res_addr    <= '0;
            res_granted <= 1'b0;
            case (action)
              ACT_ALLOC: state <= S_FIND;
              ACT_POP: begin
                top_index <= pop_index;
                state     <= S_WRITE;
              end
              ACT_RESET: begin
                top_index <= '0;
                state     <= S_WRITE;
              end
              default: state <= S_WRITE;
            endcase
          end
        end
        S_FIND: begin
          if (in_heap) begin
            off   <= top_index - heap_start;
            state <= S_POS;
          end else if (heap == LAST_HEAP) begin
            // top lies past the last heap
            state <= S_WRITE;
          end else begin
            heap <= heap + HW'(1);
          end
        end
        S_POS: begin
          state <= S_FIT;
        end
        S_FIT: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (try_stat.fit) begin
            top_index   <= heap_start + try_stat.end_pos - base_sel;
            res_addr    <= try_stat.aligned;
            res_granted <= 1'b1;
            state       <= S_WRITE;
          end else if (heap == LAST_HEAP) begin
            // no heap left, top stays
            state <= S_WRITE;
          end else begin
            heap  <= heap + HW'(1);
            off   <= '0;
            state <= S_POS;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            address   <= res_addr;
            granted   <= res_granted;
            stack_top <= top_index;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/chsa_checker.sv
`timescale 1ns / 1ps
module chsa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [chsa_pkg::ADDR_W-1:0]   address,
  input logic                          granted,
  input logic [chsa_pkg::ADDR_W-1:0]   stack_top
);
  import chsa_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(address) && $stable(granted)
      && $stable(stack_top))
    else $error("result changed while stalled");

  // one item at a time
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  // failed or non-allocate results carry address zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !granted |-> address == '0)
    else $error("address nonzero without grant");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind chained_heap_stack_allocator_unit chsa_checker u_chsa_checker (.*);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import chsa_pkg::*;

  // action code the block leaves unused
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  // first register index with nothing behind it
  localparam int REG_NONE_FIRST = REG_HEAP0_BASE + BASE_REGS;
  localparam int HEAPS_USED =
    (HEAP_COUNT_DEFAULT < BASE_REGS) ? HEAP_COUNT_DEFAULT : BASE_REGS;
  localparam logic [63:0] ADDR_SPAN = 64'h1_0000_0000;

  // settle time covers the longest allocate plus margin for stalls
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [ACTION_W-1:0] op;
    logic [SIZE_W-1:0]   req_size;
    logic [ALIGN_W-1:0]  align;
    logic [ADDR_W-1:0]   pop_to;
  } alloc_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              granted;
    logic [ADDR_W-1:0] top;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   in_valid   = 1'b0;
  logic                   in_ready;
  logic [ACTION_W-1:0]    action     = '0;
  logic [SIZE_W-1:0]      alloc_size = '0;
  logic [ALIGN_W-1:0]     align_log2 = '0;
  logic [ADDR_W-1:0]      pop_index  = '0;
  logic                   out_valid;
  logic                   out_ready  = 1'b0;
  logic [ADDR_W-1:0]      address;
  logic                   granted;
  logic [ADDR_W-1:0]      stack_top;
  logic                   cfg_write  = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  // shadow copy of the block's registers and stack pointer
  logic [LOG2_W-1:0] base_log2_sh = BASE_LOG2_RESET;
  logic [ADDR_W-1:0] heap_base_sh [BASE_REGS] = '{default: '0};
  logic [ADDR_W-1:0] stack_top_sh = '0;

  alloc_req_t pending_reqs[$];
  grant_t     expected_grants[$];
  alloc_req_t cur_req;

  int failures  = 0;
  int idle_pct  = 0;
  int send_gap  = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;

  chained_heap_stack_allocator_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .alloc_size(alloc_size),
    .align_log2(align_log2),
    .pop_index (pop_index),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .address   (address),
    .granted   (granted),
    .stack_top (stack_top),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // allocator prediction
  // ---------------------------------------------------------------------------

  // base size log2 is saturated into 4..24
  function automatic int clamped_log2();
    if (base_log2_sh < BASE_LOG2_MIN) return BASE_LOG2_MIN;
    if (base_log2_sh > BASE_LOG2_MAX) return BASE_LOG2_MAX;
    return base_log2_sh;
  endfunction

  // try to place a request in heap h at byte offset off
  function automatic bit fits_heap(input int h, input logic [63:0] off,
                                   input logic [63:0] sz, input int al,
                                   output logic [63:0] addr, output logic [63:0] nxt);
    logic [63:0] blk, first_idx, hsize, hbase, hend, mask, aligned;
    blk       = 64'd1 << clamped_log2();
    first_idx = blk * ((64'd1 << h) - 64'd1);
    hsize     = blk << h;
    hbase     = {32'd0, heap_base_sh[h]};
    hend      = hbase + hsize;
    // heap is cut off at the end of the address space
    if (hend > ADDR_SPAN) hend = ADDR_SPAN;
    mask    = (64'd1 << al) - 64'd1;
    aligned = (hbase + off + mask) & ~mask;
    addr    = aligned;
    nxt     = first_idx + (aligned - hbase) + sz;
    return !(aligned >= ADDR_SPAN || aligned + sz > hend);
  endfunction

  // expected result of one item, advances the shadow stack pointer
  function automatic grant_t predict_grant(input alloc_req_t req);
    grant_t      g;
    logic [63:0] blk, quot, off, addr, nxt;
    int          h;
    bit          ok;
    g = '0;
    if (req.op == ACT_ALLOC) begin
      blk  = 64'd1 << clamped_log2();
      quot = {32'd0, stack_top_sh} / blk + 64'd1;
      h = 0;
      // heap holding the current top: floor(log2(top / B + 1))
      while (h < 63 && (quot >> (h + 1)) != 0) h++;
      // top past the last heap fails without touching anything
      if (h < HEAPS_USED) begin
        off = {32'd0, stack_top_sh} - blk * ((64'd1 << h) - 64'd1);
        ok  = fits_heap(h, off, {40'd0, req.req_size}, req.align, addr, nxt);
        // spill to the start of each following heap
        while (!ok && h + 1 < HEAPS_USED) begin
          h++;
          ok = fits_heap(h, 64'd0, {40'd0, req.req_size}, req.align, addr, nxt);
        end
        if (ok) begin
          g.address    = addr[ADDR_W-1:0];
          g.granted    = 1'b1;
          stack_top_sh = nxt[ADDR_W-1:0];
        end
      end
    end else if (req.op == ACT_POP) begin
      stack_top_sh = req.pop_to;
    end else if (req.op == ACT_RESET) begin
      stack_top_sh = '0;
    end
    g.top = stack_top_sh;
    return g;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic alloc_req_t mk_req(input logic [ACTION_W-1:0] op,
                                        input logic [SIZE_W-1:0] sz,
                                        input logic [ALIGN_W-1:0] al,
                                        input logic [ADDR_W-1:0] idx);
    alloc_req_t r;
    r.op       = op;
    r.req_size = sz;
    r.align    = al;
    r.pop_to   = idx;
    return r;
  endfunction

  // mostly allocations sized to the current heaps, so the stack walks through them
  function automatic alloc_req_t rand_request();
    alloc_req_t  r;
    logic [63:0] blk;
    int          pick, sel;
    blk        = 64'd1 << clamped_log2();
    r.op       = ACT_ALLOC;
    r.req_size = SIZE_W'($urandom);
    r.align    = ALIGN_W'($urandom);
    r.pop_to   = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) r.req_size = '0;
      else if (sel < 65) r.req_size = SIZE_W'($urandom_range(0, 32'(blk >> 3)));
      else if (sel < 88) r.req_size = SIZE_W'($urandom_range(0, 32'(blk << 1)));
      sel = $urandom_range(0, 99);
      if (sel < 70) r.align = ALIGN_W'($urandom_range(0, 4));
      else if (sel < 90) r.align = ALIGN_W'($urandom_range(0, 8));
    end else if (pick < 85) begin
      r.op = ACT_POP;
      // mostly inside the heap chain, sometimes far beyond it
      if ($urandom_range(0, 4) != 0) r.pop_to = $urandom_range(0, 32'((blk << 4) - 1));
    end else if (pick < 95) begin
      r.op = ACT_RESET;
    end else begin
      r.op = ACT_UNUSED;
    end
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_BASE_SIZE_LOG2) base_log2_sh = data[LOG2_W-1:0];
    else if (idx >= REG_HEAP0_BASE && idx < REG_NONE_FIRST)
      heap_base_sh[idx - REG_HEAP0_BASE] = data;
  endtask

  // full register set plus one write to an index with no register
  task automatic program_regs(input logic [LOG2_W-1:0] log2v,
                              input logic [31:0] b0, input logic [31:0] b1,
                              input logic [31:0] b2, input logic [31:0] b3);
    logic [31:0] upper;
    upper = $urandom;
    write_reg(REG_BASE_SIZE_LOG2, {upper[31:LOG2_W], log2v});
    write_reg(REG_HEAP0_BASE, b0);
    write_reg(REG_HEAP0_BASE + 3'd1, b1);
    write_reg(REG_HEAP0_BASE + 3'd2, b2);
    write_reg(REG_HEAP0_BASE + 3'd3, b3);
    write_reg(CFG_INDEX_W'($urandom_range(REG_NONE_FIRST, 7)), $urandom);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // wait until every item went in and every result came out, then let the block settle
  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_grants.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_random(input int idle, input int n);
    idle_pct = idle;
    repeat (n) pending_reqs.push_back(rand_request());
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // input driver: presents queued items, random gaps between them
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      // item taken: work out what must come back for it
      if (in_valid && in_ready) expected_grants.push_back(predict_grant(cur_req));
      // free to present a new item unless one is still held
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          // start an idle burst
          send_gap = $urandom_range(0, 10);
          in_valid <= 1'b0;
        end else begin
          cur_req = pending_reqs.pop_front();
          in_valid   <= 1'b1;
          action     <= cur_req.op;
          alloc_size <= cur_req.req_size;
          align_log2 <= cur_req.align;
          pop_index  <= cur_req.pop_to;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor with random back-pressure
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          $error("result item with no item pending: address %h granted %b stack_top %h",
                 address, granted, stack_top);
          failures++;
        end else begin
          want = expected_grants.pop_front();
          if (address !== want.address) begin
            $error("address: expected %h, actual %h", want.address, address);
            failures++;
          end
          if (granted !== want.granted) begin
            $error("granted: expected %b, actual %b", want.granted, granted);
            failures++;
          end
          if (stack_top !== want.top) begin
            $error("stack_top: expected %h, actual %h", want.top, stack_top);
            failures++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
        recv_stall = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: too long without any item moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: B = 4096, all heaps at address 0
    // heap index starts 0, 4096, 12288, 28672; chain ends at 61440
    program_regs(BASE_LOG2_RESET, 32'd0, 32'd0, 32'd0, 32'd0);
    idle_pct = 25;
    pending_reqs.push_back(mk_req(ACT_ALLOC, 24'd0, 4'd0, 32'd0));          // zero size
    pending_reqs.push_back(mk_req(ACT_ALLOC, 24'd1, 4'd0, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk_req(ACT_ALLOC, 24'd8, 4'd3, 32'd0));          // align up
    pending_reqs.push_back(mk_req(ACT_ALLOC, 24'd4080, 4'd4, 32'd0));       // exact fill of heap 0
    pending_reqs.push_back(mk_req(ACT_ALLOC, 24'd1, 4'd0, 32'd0));          // lands in heap 1
    pending_reqs.push_back(mk_req(ACT_ALLOC, 24'hFF_FFFF, 4'd0, 32'd0));    // fits nowhere
    pending_reqs.push_back(mk_req(ACT_ALLOC, 24'd16, 4'hF, 32'd0));         // spills from heap 1 to 2
    pending_reqs.push_back(mk_req(ACT_POP, 24'hFF_FFFF, 4'hF, 32'hFFFF_FFFF)); // top far beyond chain
    pending_reqs.push_back(mk_req(ACT_ALLOC, 24'd0, 4'd0, 32'd0));
    pending_reqs.push_back(mk_req(ACT_UNUSED, 24'hFF_FFFF, 4'hF, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk_req(ACT_RESET, 24'hFF_FFFF, 4'hF, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk_req(ACT_POP, 24'd0, 4'd0, 32'd61432));        // near end of last heap
    pending_reqs.push_back(mk_req(ACT_ALLOC, 24'd16, 4'd0, 32'd0));         // no heap left
    pending_reqs.push_back(mk_req(ACT_POP, 24'd0, 4'd0, 32'd61440));        // exactly past the chain
    pending_reqs.push_back(mk_req(ACT_ALLOC, 24'd0, 4'd0, 32'd0));
    pending_reqs.push_back(mk_req(ACT_POP, 24'd0, 4'd0, 32'd0));
    pending_reqs.push_back(mk_req(ACT_ALLOC, 24'd0, 4'hF, 32'd0));          // max alignment at zero
    pending_reqs.push_back(mk_req(ACT_ALLOC, 24'd5, 4'hC, 32'd0));
    run_random(25, 160);

    // smallest heaps, scattered bases, no idling
    program_regs(BASE_LOG2_MIN, $urandom, $urandom, $urandom, $urandom);
    run_random(0, 150);

    // base size below range saturates; heaps pressed against the address space end
    program_regs(5'd0, 32'hFFFF_FFF0, 32'hFFFF_FFE8, 32'hFFFF_FFFF, 32'hFFFF_FFC0);
    run_random(40, 150);

    // largest heaps, some running off the end of the address space
    program_regs(BASE_LOG2_MAX, 32'd0, 32'hFF00_0000, 32'hFFFF_FFFF, 32'hFE80_0000);
    run_random(10, 150);

    // base size above range saturates to the largest
    program_regs(5'd31, $urandom, $urandom, $urandom, $urandom);
    run_random(60, 120);

    program_regs(LOG2_W'($urandom_range(4, 10)), $urandom, $urandom, $urandom, $urandom);
    run_random(25, 150);

    // closing stretch with no idling on either side
    program_regs(5'd5, 32'h1000_0000, 32'h1000_0020, 32'h7FFF_FFC0, 32'h8000_0001);
    run_random(0, 150);

    if (expected_grants.size() != 0) begin
      $error("%0d expected result items never arrived", expected_grants.size());
      failures++;
    end
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
